// ----- src/bqr_pkg.sv -----
`default_nettype none
package bqr_pkg;

  // Queue geometry
  localparam int Depth       = 64;
  localparam int HandleWidth = 32;
  localparam int AddrW       = $clog2(Depth);
  localparam int CntW        = $clog2(Depth + 1);

  // Request codes
  localparam logic [2:0] FuncEnq    = 3'd0;
  localparam logic [2:0] FuncDeq    = 3'd1;
  localparam logic [2:0] FuncRemove = 3'd2;
  localparam logic [2:0] FuncSeek   = 3'd3;
  localparam logic [2:0] FuncNext   = 3'd4;

  // Result status codes
  localparam logic [1:0] StOk   = 2'd0;
  localparam logic [1:0] StNull = 2'd1;
  localparam logic [1:0] StFull = 2'd2;
  localparam logic [1:0] StNone = 2'd3;

endpackage
`default_nettype wire

// ----- src/bqr_ram.sv -----
`default_nettype none
module bqr_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- src/bounded_queue_with_remove_unit.sv -----
`default_nettype none
// Bounded FIFO of nonzero handles with remove-by-value and an ordinal walk.
//
// Request channel: start_i with func_i / data_in_i; a transaction is taken
// on a rising edge with start_i high and busy_o low.
// Result channel: valid_o strobes for exactly one cycle with status_o,
// data_out_o, count_o, is_empty_o and is_full_o. The receiver cannot stall;
// the result must be captured in that cycle.
// Config channel: cfg_valid_i / cfg_ready_o carry max_entries; ready is
// always high. Write it only while the block is idle.
//
// Result timing by request type:
//   enqueue, seek, spare codes, rejected requests: answered from idle, one
//   per cycle. dequeue, get-next: wait on the slot RAM's registered read
//   in StRead, busy meanwhile. remove (nonzero key, non-empty queue): one
//   RAM access per ordinal, hit or miss; busy_o falls as the strobe rises.
// All entries live in one single-port-write, single-port-read RAM with a
// registered read, so the remove search and shift move one slot per cycle.
//
// Reset: queue empty, head at slot 0, no walk, limit back to Depth. Slot
// contents are not cleared; only occupied slots are ever read.
module bounded_queue_with_remove_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // request
  input  wire logic                           start_i,
  output logic                                busy_o,
  input  wire logic [2:0]                     func_i,
  input  wire logic [bqr_pkg::HandleWidth-1:0] data_in_i,
  // configuration
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [bqr_pkg::CntW-1:0]       cfg_data_i,
  // result
  output logic                                valid_o,
  output logic [1:0]                          status_o,
  output logic [bqr_pkg::HandleWidth-1:0]     data_out_o,
  output logic [bqr_pkg::CntW-1:0]            count_o,
  output logic                                is_empty_o,
  output logic                                is_full_o
);

  import bqr_pkg::*;

  // Sequencer states
  localparam logic [1:0] StIdle  = 2'd0;  // taking requests
  localparam logic [1:0] StRead  = 2'd1;  // dequeue / get-next read in flight
  localparam logic [1:0] StSrch  = 2'd2;  // streaming reads looking for key
  localparam logic [1:0] StShift = 2'd3;  // closing the gap after a match

  logic [1:0]             state_q, state_d;
  logic [2:0]             func_q, func_d;
  logic [HandleWidth-1:0] key_q, key_d;
  logic [CntW-1:0]        max_q;
  logic [CntW-1:0]        count_q, count_d;
  logic [AddrW-1:0]       head_q, head_d;
  logic [CntW-1:0]        wpos_q, wpos_d;
  logic                   wact_q, wact_d;
  logic [CntW-1:0]        idx_q, idx_d;
  logic                   pend_q, pend_d;
  logic                   res_valid_q, res_valid_d;
  logic [1:0]             status_q, status_d;
  logic [HandleWidth-1:0] dout_q, dout_d;

  logic [CntW-1:0]        limit;
  logic                   ram_we, ram_re;
  logic [AddrW-1:0]       ram_waddr, ram_raddr;
  logic [HandleWidth-1:0] ram_wdata, ram_rdata;
  logic                   match;

  // Physical slot of an ordinal counted from the head; the sum stays below
  // twice the depth, so one compare and subtract wraps it.
  function automatic logic [AddrW-1:0] slot_of(input logic [AddrW-1:0] head,
                                               input logic [CntW-1:0]  ord);
    logic [CntW:0] sum;
    sum = {{(CntW + 1 - AddrW){1'b0}}, head} + {1'b0, ord};
    if (sum >= (CntW + 1)'(Depth)) begin
      sum = sum - (CntW + 1)'(Depth);
    end
    return sum[AddrW-1:0];
  endfunction

  // Zero or an over-large setting falls back to the full depth
  always_comb begin
    if (max_q == '0 || max_q > CntW'(Depth)) begin
      limit = CntW'(Depth);
    end else begin
      limit = max_q;
    end
  end

  assign match = pend_q && (ram_rdata == key_q);

  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    key_d       = key_q;
    count_d     = count_q;
    head_d      = head_q;
    wpos_d      = wpos_q;
    wact_d      = wact_q;
    idx_d       = idx_q;
    pend_d      = pend_q;
    res_valid_d = 1'b0;
    status_d    = status_q;
    dout_d      = dout_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;

    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          func_d = func_i;
          key_d  = data_in_i;
          unique case (func_i)
            FuncEnq: begin
              res_valid_d = 1'b1;
              dout_d      = '0;
              // null check ranks above the full check
              if (data_in_i == '0) begin
                status_d = StNull;
              end else if (count_q >= limit) begin
                status_d = StFull;
              end else begin
                status_d  = StOk;
                ram_we    = 1'b1;
                ram_waddr = slot_of(head_q, count_q);
                ram_wdata = data_in_i;
                count_d   = count_q + CntW'(1);
              end
            end
            FuncDeq: begin
              if (count_q == '0) begin
                res_valid_d = 1'b1;
                status_d    = StNone;
                dout_d      = '0;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = head_q;
                state_d   = StRead;
              end
            end
            FuncRemove: begin
              if (data_in_i == '0 || count_q == '0) begin
                res_valid_d = 1'b1;
                status_d    = StNone;
                dout_d      = '0;
              end else begin
                idx_d   = '0;
                pend_d  = 1'b0;
                state_d = StSrch;
              end
            end
            FuncSeek: begin
              wpos_d      = '0;
              wact_d      = (count_q != '0);
              res_valid_d = 1'b1;
              status_d    = (count_q != '0) ? StOk : StNone;
              dout_d      = '0;
            end
            FuncNext: begin
              if (!wact_q) begin
                res_valid_d = 1'b1;
                status_d    = StNone;
                dout_d      = '0;
              end else if (wpos_q >= count_q) begin
                wact_d      = 1'b0;
                res_valid_d = 1'b1;
                status_d    = StNone;
                dout_d      = '0;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = slot_of(head_q, wpos_q);
                state_d   = StRead;
              end
            end
            default: begin
              // unused code: no effect
              res_valid_d = 1'b1;
              status_d    = StOk;
              dout_d      = '0;
            end
          endcase
        end
      end

      StRead: begin
        res_valid_d = 1'b1;
        status_d    = StOk;
        dout_d      = ram_rdata;
        if (func_q == FuncDeq) begin
          head_d  = (head_q == AddrW'(Depth - 1)) ? '0 : head_q + AddrW'(1);
          count_d = count_q - CntW'(1);
        end else begin
          wpos_d = wpos_q + CntW'(1);
        end
        state_d = StIdle;
      end

      StSrch: begin
        // idx_q is the next ordinal to read; a pending word is idx_q - 1
        if (match) begin
          if (idx_q < count_q) begin
            ram_re    = 1'b1;
            ram_raddr = slot_of(head_q, idx_q);
            idx_d     = idx_q - CntW'(1);
            state_d   = StShift;
          end else begin
            // matched the tail: nothing to move
            res_valid_d = 1'b1;
            status_d    = StOk;
            dout_d      = '0;
            count_d     = count_q - CntW'(1);
            state_d     = StIdle;
          end
        end else if (idx_q < count_q) begin
          ram_re    = 1'b1;
          ram_raddr = slot_of(head_q, idx_q);
          idx_d     = idx_q + CntW'(1);
          pend_d    = 1'b1;
        end else begin
          res_valid_d = 1'b1;
          status_d    = StNone;
          dout_d      = '0;
          state_d     = StIdle;
        end
      end

      StShift: begin
        // read data is the entry after idx_q; move it down one place
        ram_we    = 1'b1;
        ram_waddr = slot_of(head_q, idx_q);
        ram_wdata = ram_rdata;
        if ((idx_q + CntW'(2)) < count_q) begin
          ram_re    = 1'b1;
          ram_raddr = slot_of(head_q, idx_q + CntW'(2));
          idx_d     = idx_q + CntW'(1);
        end else begin
          res_valid_d = 1'b1;
          status_d    = StOk;
          dout_d      = '0;
          count_d     = count_q - CntW'(1);
          state_d     = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      head_q      <= '0;
      wpos_q      <= '0;
      wact_q      <= 1'b0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
      max_q       <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      head_q      <= head_d;
      wpos_q      <= wpos_d;
      wact_q      <= wact_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      res_valid_q <= res_valid_d;
      if (cfg_valid_i) begin
        max_q <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    func_q   <= func_d;
    key_q    <= key_d;
    status_q <= status_d;
    dout_q   <= dout_d;
  end

  bqr_ram #(
    .Width(HandleWidth),
    .Depth(Depth)
  ) u_slots (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign busy_o      = (state_q != StIdle);
  assign cfg_ready_o = 1'b1;
  assign valid_o     = res_valid_q;
  assign status_o    = status_q;
  assign data_out_o  = dout_q;
  // count register already holds the post-request value during the strobe
  assign count_o     = count_q;
  assign is_empty_o  = (count_q == '0);
  assign is_full_o   = (count_q >= limit);

endmodule
`default_nettype wire
